// ===== hdl/fte_pkg.sv =====
// Shared types, codes and defaults for the page-mapped FTL engine.
`timescale 1ns / 1ps
package fte_pkg;

    localparam int PAGES_PER_BLOCK_DEF = 16;
    localparam int PHYSICAL_BLOCKS_DEF = 16;
    localparam int LOGICAL_BLOCKS_DEF  = 12;
    localparam int CACHE_ENTRIES_DEF   = 10;

    localparam logic [8:0] GC_THRESHOLD_RST = 9'd145;
    localparam logic [8:0] USED_MAX         = 9'd511;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_TRIM  = 2'd2;
    localparam logic [1:0] FUNC_RSVD  = 2'd3;

    localparam logic [3:0] KIND_CACHED     = 4'd0;
    localparam logic [3:0] KIND_PROGRAM    = 4'd1;
    localparam logic [3:0] KIND_GC_COPY    = 4'd2;
    localparam logic [3:0] KIND_ERASE      = 4'd3;
    localparam logic [3:0] KIND_READ_FLASH = 4'd4;
    localparam logic [3:0] KIND_READ_CACHE = 4'd5;
    localparam logic [3:0] KIND_READ_ZERO  = 4'd6;
    localparam logic [3:0] KIND_TRIM_DONE  = 4'd7;
    localparam logic [3:0] KIND_FULL_ERR   = 4'd8;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] lba;
    } cmd_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] dst_block;
        logic [3:0] dst_page;
        logic [3:0] src_block;
        logic [3:0] src_page;
        logic [3:0] slot;
        logic [7:0] page_lba;
        logic       last;
    } res_t;

    typedef struct packed {
        logic       remove;
        logic       append;
        logic [7:0] key;
    } cache_req_t;

    typedef struct packed {
        logic [7:0] head_lba;
        logic [3:0] head_slot;
        logic       hit;
        logic [3:0] hit_slot;
        logic       free_ok;
        logic [3:0] free_slot;
        logic       at_limit;
    } cache_sts_t;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic       clr_en;
        logic [7:0] wr_data;
    } map_req_t;

    typedef struct packed {
        logic alloc;
        logic erase;
    } alloc_req_t;

endpackage

// ===== hdl/fte_map.sv =====
// Logical-to-physical map: synchronous memory plus per-entry mapped flags.
`timescale 1ns / 1ps
module fte_map import fte_pkg::*; #(
    parameter int DEPTH = LOGICAL_BLOCKS_DEF * PAGES_PER_BLOCK_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  map_req_t      req,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    output logic          rd_valid,
    output logic [7:0]    rd_data
);

    logic [7:0]       map_mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic             rd_valid_reg;
    logic [7:0]       rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            map_mem[wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // an entry whose flag is clear reads as unmapped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (req.clr_en) begin
                vld_reg[wr_addr] <= 1'b0;
            end
            if (req.rd_en) begin
                rd_valid_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_data  = rd_data_reg;

endmodule

// ===== hdl/fte_cache.sv =====
// Ordered write cache: queue of logical pages with their data slots.
`timescale 1ns / 1ps
module fte_cache import fte_pkg::*; #(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cache_req_t req,
    output cache_sts_t sts
);

    localparam int SLOTS = CACHE_ENTRIES + 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int QW    = $clog2(SLOTS);

    logic [7:0]    lba_q_reg  [SLOTS];
    logic [3:0]    slot_q_reg [SLOTS];
    logic [CW-1:0] count_reg, count_next;
    logic [SLOTS-1:0] free_reg, free_next;

    logic          match_found;
    logic [QW-1:0] match_idx;
    logic          free_any;
    logic [QW-1:0] free_idx;
    logic          do_remove, do_append;

    always_comb begin
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (CW'(i) < count_reg && lba_q_reg[i] == req.key) begin
                match_found = 1'b1;
                match_idx   = QW'(i);
            end
        end
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                free_any = 1'b1;
                free_idx = QW'(i);
            end
        end
    end

    assign do_remove = req.remove && match_found;
    assign do_append = req.append && sts.free_ok;

    always_comb begin
        sts.head_lba  = lba_q_reg[0];
        sts.head_slot = slot_q_reg[0];
        sts.hit       = match_found;
        sts.hit_slot  = slot_q_reg[match_idx];
        sts.free_ok   = free_any && (count_reg < CW'(SLOTS));
        sts.free_slot = 4'(free_idx);
        sts.at_limit  = count_reg >= CW'(CACHE_ENTRIES);
    end

    always_comb begin
        count_next = count_reg;
        free_next  = free_reg;
        if (do_remove) begin
            count_next = count_reg - CW'(1);
            free_next[sts.hit_slot[QW-1:0]] = 1'b1;
        end else if (do_append) begin
            count_next = count_reg + CW'(1);
            free_next[free_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            free_reg  <= '1;
        end else begin
            count_reg <= count_next;
            free_reg  <= free_next;
        end
    end

    // removal closes the gap by shifting younger entries down one place
    for (genvar j = 0; j < SLOTS; j++) begin : g_entry
        if (j < SLOTS - 1) begin : g_shift
            always_ff @(posedge aclk) begin
                if (do_remove && QW'(j) >= match_idx) begin
                    lba_q_reg[j]  <= lba_q_reg[j+1];
                    slot_q_reg[j] <= slot_q_reg[j+1];
                end else if (do_append && count_reg == CW'(j)) begin
                    lba_q_reg[j]  <= req.key;
                    slot_q_reg[j] <= 4'(free_idx);
                end
            end
        end else begin : g_tail
            always_ff @(posedge aclk) begin
                if (do_append && count_reg == CW'(j)) begin
                    lba_q_reg[j]  <= req.key;
                    slot_q_reg[j] <= 4'(free_idx);
                end
            end
        end
    end

endmodule

// ===== hdl/fte_alloc.sv =====
// Sequential page allocator, block-full flags and used page counter.
`timescale 1ns / 1ps
module fte_alloc import fte_pkg::*; #(
    parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF,
    parameter int PHYSICAL_BLOCKS = PHYSICAL_BLOCKS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  alloc_req_t                 req,
    input  logic [3:0]                 victim,
    output logic                       ok,
    output logic [3:0]                 blk,
    output logic [3:0]                 pg,
    output logic [8:0]                 used,
    output logic [PHYSICAL_BLOCKS-1:0] full
);

    localparam int BIW = $clog2(PHYSICAL_BLOCKS);
    localparam int PIW = $clog2(PAGES_PER_BLOCK);

    logic                       ptr_vld_reg;
    logic [BIW-1:0]             ptr_blk_reg;
    logic [PIW-1:0]             ptr_pg_reg;
    logic [PHYSICAL_BLOCKS-1:0] full_reg, full_upd;
    logic [8:0]                 used_reg;
    logic [BIW-1:0]             nb;
    logic [PIW-1:0]             np;

    always_comb begin
        full_upd = full_reg;
        ok       = 1'b0;
        nb       = ptr_blk_reg;
        np       = '0;
        if (ptr_vld_reg && ptr_pg_reg != PIW'(PAGES_PER_BLOCK - 1)) begin
            ok = 1'b1;
            np = ptr_pg_reg + PIW'(1);
        end else begin
            if (ptr_vld_reg) begin
                full_upd[ptr_blk_reg] = 1'b1;
            end
            // lowest block not yet full
            for (int b = PHYSICAL_BLOCKS - 1; b >= 0; b--) begin
                if (!full_upd[b]) begin
                    ok = 1'b1;
                    nb = BIW'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_vld_reg <= 1'b0;
            ptr_blk_reg <= '0;
            ptr_pg_reg  <= '0;
            full_reg    <= '0;
            used_reg    <= '0;
        end else if (req.alloc) begin
            full_reg    <= full_upd;
            ptr_vld_reg <= ok;
            ptr_blk_reg <= nb;
            ptr_pg_reg  <= np;
            if (ok && used_reg != USED_MAX) begin
                used_reg <= used_reg + 9'd1;
            end
        end else if (req.erase) begin
            full_reg[victim[BIW-1:0]] <= 1'b0;
            used_reg <= (used_reg >= 9'(PAGES_PER_BLOCK)) ?
                        used_reg - 9'(PAGES_PER_BLOCK) : 9'd0;
        end
    end

    assign blk  = 4'(nb);
    assign pg   = 4'(np);
    assign used = used_reg;
    assign full = full_reg;

endmodule

// ===== hdl/page_mapped_ftl_engine.sv =====
// Top level: command sequencer, garbage collection and result register.
// One command at a time. Garbage collection runs a count pass over the logical
// pages and a victim pick over the physical blocks, then, once a victim is
// found, a copy pass over the logical pages and an erase. Synchronous reset
// clears map flags at once, no clearing pass; threshold resets to 145.
`timescale 1ns / 1ps
module page_mapped_ftl_engine import fte_pkg::*; #(
    parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF,
    parameter int PHYSICAL_BLOCKS = PHYSICAL_BLOCKS_DEF,
    parameter int LOGICAL_BLOCKS  = LOGICAL_BLOCKS_DEF,
    parameter int CACHE_ENTRIES   = CACHE_ENTRIES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  cmd_t       s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data
);

    localparam int LP  = LOGICAL_BLOCKS * PAGES_PER_BLOCK;
    localparam int AW  = $clog2(LP);
    localparam int BIW = $clog2(PHYSICAL_BLOCKS);
    localparam int VCW = $clog2(LP + 1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISP     = 4'd1;
    localparam logic [3:0] ST_RD_WAIT  = 4'd2;
    localparam logic [3:0] ST_W_APPEND = 4'd3;
    localparam logic [3:0] ST_FLUSH    = 4'd4;
    localparam logic [3:0] ST_SCAN_RD  = 4'd5;
    localparam logic [3:0] ST_SCAN_CHK = 4'd6;
    localparam logic [3:0] ST_VSEL     = 4'd7;
    localparam logic [3:0] ST_ERASE    = 4'd8;
    localparam logic [3:0] ST_PROG     = 4'd9;
    localparam logic [3:0] ST_FAIL     = 4'd10;

    logic [3:0]     state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic           phase_reg, phase_next;
    logic [VCW-1:0] vcnt_reg [PHYSICAL_BLOCKS];
    logic [VCW-1:0] vcnt_next [PHYSICAL_BLOCKS];
    logic [BIW-1:0] vb_reg, vb_next;
    logic [VCW-1:0] least_reg, least_next;
    logic [BIW-1:0] victim_reg, victim_next;
    logic           found_reg, found_next;
    logic [3:0]     slot_reg, slot_next;
    logic [8:0]     thr_reg;
    res_t           out_reg;
    logic           m_valid_reg;

    cache_req_t cache_req;
    cache_sts_t cache_sts;
    map_req_t   map_req;
    alloc_req_t alloc_req;
    logic [AW-1:0] map_rd_addr, map_wr_addr;
    logic          map_vld;
    logic [7:0]    map_data;
    logic [3:0]    map_blk;
    logic          al_ok;
    logic [3:0]    al_blk, al_pg;
    logic [8:0]    used;
    logic [PHYSICAL_BLOCKS-1:0] blk_full;

    logic emit, emit_ok, bad_cmd, idx_last, take;
    res_t res;

    fte_map #(.DEPTH(LP), .AW(AW)) u_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (map_req),
        .rd_addr  (map_rd_addr),
        .wr_addr  (map_wr_addr),
        .rd_valid (map_vld),
        .rd_data  (map_data)
    );

    fte_cache #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cache_req),
        .sts     (cache_sts)
    );

    fte_alloc #(
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
        .PHYSICAL_BLOCKS (PHYSICAL_BLOCKS)
    ) u_alloc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alloc_req),
        .victim  (4'(victim_reg)),
        .ok      (al_ok),
        .blk     (al_blk),
        .pg      (al_pg),
        .used    (used),
        .full    (blk_full)
    );

    assign map_blk  = map_data[7:4];
    assign emit_ok  = !m_valid_reg || m_ready;
    assign bad_cmd  = ({1'b0, cmd_reg.lba} >= 9'(LP)) || (cmd_reg.func == FUNC_RSVD);
    assign idx_last = idx_reg == AW'(LP - 1);
    assign take     = blk_full[vb_reg] && (vcnt_reg[vb_reg] < least_reg);

    assign map_rd_addr = (state_reg == ST_DISP) ? cmd_reg.lba[AW-1:0] : idx_reg;
    assign map_wr_addr = (state_reg == ST_SCAN_CHK) ? idx_reg :
                         (state_reg == ST_PROG) ? cache_sts.head_lba[AW-1:0] :
                         cmd_reg.lba[AW-1:0];

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        vcnt_next   = vcnt_reg;
        vb_next     = vb_reg;
        least_next  = least_reg;
        victim_next = victim_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        cache_req   = '0;
        cache_req.key = (state_reg == ST_PROG) ? cache_sts.head_lba : cmd_reg.lba;
        map_req     = '0;
        alloc_req   = '0;
        emit        = 1'b0;
        res         = '0;
        res.page_lba = cmd_reg.lba;
        res.last    = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (bad_cmd) begin
                    if (emit_ok) begin
                        emit       = 1'b1;
                        res.kind   = KIND_FULL_ERR;
                        state_next = ST_IDLE;
                    end
                end else begin
                    case (cmd_reg.func)
                        FUNC_READ: begin
                            map_req.rd_en = 1'b1;
                            state_next    = ST_RD_WAIT;
                        end
                        FUNC_TRIM: begin
                            if (emit_ok) begin
                                map_req.clr_en   = 1'b1;
                                cache_req.remove = 1'b1;
                                emit             = 1'b1;
                                res.kind         = KIND_TRIM_DONE;
                                state_next       = ST_IDLE;
                            end
                        end
                        default: begin
                            map_req.clr_en   = 1'b1;
                            cache_req.remove = 1'b1;
                            state_next       = ST_W_APPEND;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                if (emit_ok) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (map_vld) begin
                        res.kind      = KIND_READ_FLASH;
                        res.dst_block = map_data[7:4];
                        res.dst_page  = map_data[3:0];
                    end else if (cache_sts.hit) begin
                        res.kind = KIND_READ_CACHE;
                        res.slot = cache_sts.hit_slot;
                    end else begin
                        res.kind = KIND_READ_ZERO;
                    end
                end
            end
            ST_W_APPEND: begin
                if (emit_ok) begin
                    emit = 1'b1;
                    if (!cache_sts.free_ok) begin
                        res.kind   = KIND_FULL_ERR;
                        state_next = ST_IDLE;
                    end else begin
                        cache_req.append = 1'b1;
                        res.kind   = KIND_CACHED;
                        res.slot   = cache_sts.free_slot;
                        res.last   = !cache_sts.at_limit;
                        slot_next  = cache_sts.free_slot;
                        state_next = cache_sts.at_limit ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (used > thr_reg) begin
                    for (int b = 0; b < PHYSICAL_BLOCKS; b++) begin
                        vcnt_next[b] = '0;
                    end
                    idx_next   = '0;
                    phase_next = 1'b0;
                    state_next = ST_SCAN_RD;
                end else begin
                    state_next = ST_PROG;
                end
            end
            ST_SCAN_RD: begin
                map_req.rd_en = 1'b1;
                state_next    = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (!phase_reg) begin
                    // first pass: valid page count per block
                    if (map_vld) begin
                        vcnt_next[map_blk[BIW-1:0]] = vcnt_reg[map_blk[BIW-1:0]] + VCW'(1);
                    end
                    if (idx_last) begin
                        vb_next    = '0;
                        least_next = VCW'(PAGES_PER_BLOCK);
                        found_next = 1'b0;
                        state_next = ST_VSEL;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_SCAN_RD;
                    end
                end else if (map_vld && map_blk == 4'(victim_reg)) begin
                    if (emit_ok) begin
                        alloc_req.alloc = 1'b1;
                        if (al_ok) begin
                            emit            = 1'b1;
                            res.kind        = KIND_GC_COPY;
                            res.dst_block   = al_blk;
                            res.dst_page    = al_pg;
                            res.src_block   = map_data[7:4];
                            res.src_page    = map_data[3:0];
                            res.page_lba    = 8'(idx_reg);
                            res.last        = 1'b0;
                            map_req.wr_en   = 1'b1;
                            map_req.wr_data = {al_blk, al_pg};
                            idx_next        = idx_reg + AW'(1);
                            state_next      = idx_last ? ST_ERASE : ST_SCAN_RD;
                        end else begin
                            state_next = ST_FAIL;
                        end
                    end
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = idx_last ? ST_ERASE : ST_SCAN_RD;
                end
            end
            ST_VSEL: begin
                if (take) begin
                    least_next  = vcnt_reg[vb_reg];
                    victim_next = vb_reg;
                    found_next  = 1'b1;
                end
                if (vb_reg == BIW'(PHYSICAL_BLOCKS - 1)) begin
                    if (found_reg || take) begin
                        idx_next   = '0;
                        phase_next = 1'b1;
                        state_next = ST_SCAN_RD;
                    end else begin
                        state_next = ST_PROG;
                    end
                end else begin
                    vb_next = vb_reg + BIW'(1);
                end
            end
            ST_ERASE: begin
                if (emit_ok) begin
                    alloc_req.erase = 1'b1;
                    emit            = 1'b1;
                    res.kind        = KIND_ERASE;
                    res.dst_block   = 4'(victim_reg);
                    res.page_lba    = 8'd0;
                    res.last        = 1'b0;
                    state_next      = ST_PROG;
                end
            end
            ST_PROG: begin
                if (emit_ok) begin
                    alloc_req.alloc = 1'b1;
                    if (al_ok) begin
                        emit             = 1'b1;
                        res.kind         = KIND_PROGRAM;
                        res.dst_block    = al_blk;
                        res.dst_page     = al_pg;
                        res.slot         = cache_sts.head_slot;
                        res.page_lba     = cache_sts.head_lba;
                        map_req.wr_en    = 1'b1;
                        map_req.wr_data  = {al_blk, al_pg};
                        cache_req.remove = 1'b1;
                        state_next       = ST_IDLE;
                    end else begin
                        state_next = ST_FAIL;
                    end
                end
            end
            ST_FAIL: begin
                // the new write is dropped from the cache
                if (emit_ok) begin
                    cache_req.remove = 1'b1;
                    emit             = 1'b1;
                    res.kind         = KIND_FULL_ERR;
                    res.slot         = slot_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            thr_reg     <= GC_THRESHOLD_RST;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        phase_reg  <= phase_next;
        vcnt_reg   <= vcnt_next;
        vb_reg     <= vb_next;
        least_reg  <= least_next;
        victim_reg <= victim_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        if (emit) begin
            out_reg <= res;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== bench/page_mapped_ftl_engine_tb.sv =====
// Self-checking bench for the FTL engine: directed and random page commands against a predictor.
`timescale 1ns / 1ps
module page_mapped_ftl_engine_tb;
    import fte_pkg::*;

    localparam int PPB      = 16;
    localparam int NBLK     = 16;
    localparam int NLPAGE   = 192;
    localparam int NCACHE   = 10;
    localparam int NSLOT    = NCACHE + 1;
    localparam logic [8:0] PTR_IDLE = 9'h1FF;
    localparam logic [8:0] PTR_FULL = 9'h1FE;
    localparam int CYCLE_LIMIT = 2000000;

    logic aclk;
    logic aresetn;
    logic s_valid, s_ready;
    cmd_t s_data;
    logic m_valid, m_ready;
    res_t m_data;
    logic cfg_valid, cfg_ready;
    logic [8:0] cfg_data;

    page_mapped_ftl_engine u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic [8:0]  pm_map [NLPAGE];
    logic        pm_full [NBLK];
    logic [8:0]  pm_ptr;
    logic [8:0]  pm_used;
    logic [11:0] pm_cq [NSLOT];
    int          pm_ccount;
    logic [10:0] pm_free;
    logic [8:0]  pm_thresh;

    cmd_t cmd_queue[$];
    res_t expected_results[$];
    int   n_errors;
    int   n_results;
    int   n_kind [16];
    bit   no_idle;
    bit   cfg_busy;
    longint cycles;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report(input string what);
        n_errors++;
        $display("mismatch: %s", what);
    endtask

    task automatic pm_reset();
        for (int i = 0; i < NLPAGE; i++) pm_map[i] = '0;
        for (int i = 0; i < NBLK; i++) pm_full[i] = 1'b0;
        pm_ptr = PTR_IDLE;
        pm_used = '0;
        pm_ccount = 0;
        pm_free = '1;
        pm_thresh = GC_THRESHOLD_RST;
    endtask

    function automatic res_t mk(input logic [3:0] k, input int db, input int dp, input int sb,
                                input int sp, input int sl, input int lba);
        res_t r;
        r.kind = k; r.dst_block = db[3:0]; r.dst_page = dp[3:0];
        r.src_block = sb[3:0]; r.src_page = sp[3:0]; r.slot = sl[3:0];
        r.page_lba = lba[7:0]; r.last = 1'b0;
        return r;
    endfunction

    task automatic used_inc();
        if (pm_used < USED_MAX) pm_used++;
    endtask

    task automatic next_page(output bit ok, output logic [8:0] pca);
        int b, p;
        ok = 0; pca = '0;
        if (pm_ptr != PTR_IDLE && pm_ptr != PTR_FULL) begin
            b = pm_ptr[7:4]; p = pm_ptr[3:0];
            if (p + 1 < PPB) begin
                pm_ptr = 9'((b << 4) | (p + 1));
                pca = pm_ptr; ok = 1;
                return;
            end
            pm_full[b] = 1'b1;
        end
        for (int i = 0; i < NBLK; i++)
            if (!pm_full[i]) begin
                pm_ptr = 9'(i << 4);
                pca = pm_ptr; ok = 1;
                return;
            end
        pm_ptr = PTR_FULL;
    endtask

    task automatic cache_drop(input int lba);
        for (int i = 0; i < pm_ccount; i++)
            if (pm_cq[i][7:0] == lba[7:0]) begin
                pm_free[pm_cq[i][11:8]] = 1'b1;
                for (int j = i; j + 1 < pm_ccount; j++) pm_cq[j] = pm_cq[j + 1];
                pm_ccount--;
                return;
            end
    endtask

    task automatic collect(inout res_t rs[$], output bit ok);
        int valid [NBLK];
        int least, victim;
        bit aok;
        logic [8:0] pca, m;
        least = PPB; victim = -1; ok = 1;
        for (int i = 0; i < NBLK; i++) valid[i] = 0;
        for (int l = 0; l < NLPAGE; l++)
            if (pm_map[l][8]) valid[pm_map[l][7:4]]++;
        for (int b = 0; b < NBLK; b++)
            if (pm_full[b] && valid[b] < least) begin
                least = valid[b]; victim = b;
            end
        if (victim < 0) return;
        for (int l = 0; l < NLPAGE; l++) begin
            m = pm_map[l];
            if (!m[8] || m[7:4] != victim) continue;
            next_page(aok, pca);
            if (!aok) begin
                ok = 0;
                return;
            end
            rs.push_back(mk(KIND_GC_COPY, pca[7:4], pca[3:0], m[7:4], m[3:0], 0, l));
            pm_map[l] = {1'b1, pca[7:0]};
            used_inc();
        end
        pm_full[victim] = 1'b0;
        pm_used = (pm_used >= PPB) ? 9'(pm_used - PPB) : '0;
        rs.push_back(mk(KIND_ERASE, victim, 0, 0, 0, 0, 0));
    endtask

    task automatic flush_head(inout res_t rs[$], output bit ok);
        int lba, sl;
        bit aok;
        logic [8:0] pca;
        ok = 1;
        if (pm_used > pm_thresh) begin
            collect(rs, aok);
            if (!aok) begin
                ok = 0;
                return;
            end
        end
        if (pm_ccount == 0) return;
        lba = pm_cq[0][7:0]; sl = pm_cq[0][11:8];
        next_page(aok, pca);
        if (!aok) begin
            ok = 0;
            return;
        end
        rs.push_back(mk(KIND_PROGRAM, pca[7:4], pca[3:0], 0, 0, sl, lba));
        used_inc();
        pm_map[lba] = {1'b1, pca[7:0]};
        cache_drop(lba);
    endtask

    task automatic predict_cmd(input cmd_t c);
        res_t rs[$];
        int lba, sl, hit;
        bit ok;
        lba = c.lba; sl = NSLOT;
        if (lba >= NLPAGE || c.func == FUNC_RSVD) begin
            rs.push_back(mk(KIND_FULL_ERR, 0, 0, 0, 0, 0, lba));
        end else if (c.func == FUNC_READ) begin
            hit = -1;
            for (int i = 0; i < pm_ccount; i++)
                if (hit < 0 && pm_cq[i][7:0] == lba[7:0]) hit = pm_cq[i][11:8];
            if (pm_map[lba][8])
                rs.push_back(mk(KIND_READ_FLASH, pm_map[lba][7:4], pm_map[lba][3:0], 0, 0, 0, lba));
            else if (hit >= 0) rs.push_back(mk(KIND_READ_CACHE, 0, 0, 0, 0, hit, lba));
            else rs.push_back(mk(KIND_READ_ZERO, 0, 0, 0, 0, 0, lba));
        end else if (c.func == FUNC_TRIM) begin
            pm_map[lba] = '0;
            cache_drop(lba);
            rs.push_back(mk(KIND_TRIM_DONE, 0, 0, 0, 0, 0, lba));
        end else begin
            cache_drop(lba);
            pm_map[lba] = '0;
            for (int s = 0; s < NSLOT; s++)
                if (sl == NSLOT && pm_free[s]) sl = s;
            if (sl >= NSLOT || pm_ccount >= NSLOT) begin
                rs.push_back(mk(KIND_FULL_ERR, 0, 0, 0, 0, 0, lba));
            end else begin
                pm_free[sl] = 1'b0;
                pm_cq[pm_ccount] = {4'(sl), 8'(lba)};
                pm_ccount++;
                rs.push_back(mk(KIND_CACHED, 0, 0, 0, 0, sl, lba));
                if (pm_ccount > NCACHE) begin
                    flush_head(rs, ok);
                    if (!ok) begin
                        cache_drop(lba);
                        rs.push_back(mk(KIND_FULL_ERR, 0, 0, 0, 0, sl, lba));
                    end
                end
            end
        end
        rs[rs.size() - 1].last = 1'b1;
        foreach (rs[i]) expected_results.push_back(rs[i]);
    endtask

    // driver: predicts at acceptance so configuration order is respected
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_cmd(s_data);
                void'(cmd_queue.pop_front());
            end
            if (s_valid && !s_ready) begin
                // hold the beat
            end else if (!cfg_busy && cmd_queue.size() > 0
                         && (no_idle || $urandom_range(99) >= 23)) begin
                s_valid <= 1'b1;
                s_data <= cmd_queue[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                n_kind[m_data.kind]++;
                if (expected_results.size() == 0) begin
                    report($sformatf("unexpected result %h", m_data));
                end else begin
                    res_t e;
                    e = expected_results.pop_front();
                    if (m_data.kind != e.kind)
                        report($sformatf("kind %0d exp %0d", m_data.kind, e.kind));
                    if (m_data.dst_block != e.dst_block)
                        report($sformatf("dst_block %0d exp %0d", m_data.dst_block, e.dst_block));
                    if (m_data.dst_page != e.dst_page)
                        report($sformatf("dst_page %0d exp %0d", m_data.dst_page, e.dst_page));
                    if (m_data.src_block != e.src_block)
                        report($sformatf("src_block %0d exp %0d", m_data.src_block, e.src_block));
                    if (m_data.src_page != e.src_page)
                        report($sformatf("src_page %0d exp %0d", m_data.src_page, e.src_page));
                    if (m_data.slot != e.slot)
                        report($sformatf("slot %0d exp %0d", m_data.slot, e.slot));
                    if (m_data.page_lba != e.page_lba)
                        report($sformatf("page_lba %0d exp %0d", m_data.page_lba, e.page_lba));
                    if (m_data.last != e.last)
                        report($sformatf("last %0d exp %0d", m_data.last, e.last));
                end
            end
            m_ready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    task automatic add_cmd(input logic [1:0] f, input int lba);
        cmd_t c;
        c.func = f; c.lba = lba[7:0];
        cmd_queue.push_back(c);
    endtask

    task automatic drain();
        while (cmd_queue.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [8:0] v);
        cfg_busy = 1;
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        pm_thresh = v;
        cfg_busy = 0;
    endtask

    // mostly writes over a narrow hot range so the map fills and GC runs
    task automatic random_batch(input int n, input int span);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 60) add_cmd(FUNC_WRITE, $urandom_range(span - 1));
            else if (r < 78) add_cmd(FUNC_READ, $urandom_range(span - 1));
            else if (r < 90) add_cmd(FUNC_TRIM, $urandom_range(span - 1));
            else if (r < 95) add_cmd(FUNC_RSVD, $urandom_range(255));
            else add_cmd(2'($urandom_range(3)), $urandom_range(255));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cycles = 0;
        n_errors = 0;
        n_results = 0;
        no_idle = 0;
        cfg_busy = 0;
        foreach (n_kind[i]) n_kind[i] = 0;
        pm_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every func, out of range, overflow flush
        set_threshold(9'd0);
        add_cmd(FUNC_READ, 0);
        add_cmd(FUNC_WRITE, 0);
        add_cmd(FUNC_READ, 0);
        add_cmd(FUNC_WRITE, 191);
        add_cmd(FUNC_WRITE, 0);
        add_cmd(FUNC_TRIM, 191);
        add_cmd(FUNC_READ, 191);
        add_cmd(FUNC_WRITE, 192);
        add_cmd(FUNC_READ, 255);
        add_cmd(FUNC_RSVD, 5);
        add_cmd(FUNC_RSVD, 255);
        for (int i = 1; i <= 11; i++) add_cmd(FUNC_WRITE, i * 17);
        add_cmd(FUNC_READ, 17);
        add_cmd(FUNC_TRIM, 0);
        drain();

        // fill the flash: small live set, many rewrites, GC at threshold 0
        set_threshold(9'd256);
        random_batch(40, 24);
        // pause until every result is in
        drain();
        set_threshold(9'd0);
        no_idle = 1;
        random_batch(40, 24);
        drain();
        no_idle = 0;
        set_threshold(9'(100 + $urandom_range(100)));
        random_batch(30, 192);
        drain();
        set_threshold(9'd511);
        random_batch(12, 192);
        drain();
        set_threshold(9'd145);
        random_batch(12, 48);
        drain();

        $display("covered %0d results: %0d programs, %0d gc copies, %0d erases, %0d errors",
                 n_results, n_kind[KIND_PROGRAM], n_kind[KIND_GC_COPY],
                 n_kind[KIND_ERASE], n_kind[KIND_FULL_ERR]);
        $display("thresholds 0, 256, 511, 145 and a random one; %0d mismatches", n_errors);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
